@@ hdl/gbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg: shared types, constants and helpers for the bus gain resolver
// Holds the register map, the configuration and pipeline word types and the
// Q1.15 arithmetic and bus lookup functions used by every stage.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // Bus topology
  localparam int NUM_BUSES = 4;
  localparam int NUM_LANES = NUM_BUSES - 1;
  localparam int IDX_W     = 3;
  localparam int PAR_W     = 2;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 16;

  localparam logic [GAIN_W-1:0] UNITY = 16'd32768;

  // Register map
  localparam logic [2:0] REG_MASTER_GAIN = 3'd0;
  localparam logic [2:0] REG_BUS1_GAIN   = 3'd1;
  localparam logic [2:0] REG_BUS2_GAIN   = 3'd2;
  localparam logic [2:0] REG_BUS3_GAIN   = 3'd3;
  localparam logic [2:0] REG_PARENT_MAP  = 3'd4;
  localparam logic [2:0] REG_MUTE_MASK   = 3'd5;
  localparam logic [2:0] REG_SOLO_MASK   = 3'd6;

  typedef struct packed {
    logic [3:0][GAIN_W-1:0] gain;
    logic [7:0]             parent_map;
    logic [3:0]             mute_mask;
    logic [3:0]             solo_mask;
  } cfg_t;

  // One category bus walking its parent chain
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [PAR_W-1:0]  cur;
    logic              mute;
    logic              self_solo;
    logic              chain_solo;
  } lane_t;

  typedef struct packed {
    logic [IDX_W-1:0]           bus_index;
    logic [GAIN_W-1:0]          lv;
    lane_t [NUM_LANES-1:0]      lanes;
  } item_t;

  // Lane after the master gain is applied
  typedef struct packed {
    logic [GAIN_W-1:0] eff;
    logic              mute;
    logic              covered;
  } fin_lane_t;

  typedef struct packed {
    logic [IDX_W-1:0]          bus_index;
    logic [GAIN_W-1:0]         lv;
    fin_lane_t [NUM_LANES-1:0] lanes;
  } mst_t;

  typedef struct packed {
    logic [GAIN_W-1:0] mix_gain;
    logic [GAIN_W-1:0] output_gain;
    logic              mix_enable;
    logic              bus_silent;
    logic              solo_silenced;
    logic              any_mixable;
    logic              bus_valid;
  } res_t;

  // Q1.15 product, truncated
  function automatic logic [GAIN_W-1:0] qmul(input logic [GAIN_W-1:0] a,
                                             input logic [GAIN_W-1:0] b);
    logic [2*GAIN_W-1:0] p;
    p = {{GAIN_W{1'b0}}, a} * {{GAIN_W{1'b0}}, b};
    return p[2*GAIN_W-2:GAIN_W-1];
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of(input cfg_t c, input logic [PAR_W-1:0] i);
    logic [GAIN_W-1:0] g;
    g = c.gain[i];
    if (int'(i) >= NUM_BUSES) begin
      return UNITY;
    end
    return (g > UNITY) ? UNITY : g;
  endfunction

  function automatic logic [PAR_W-1:0] parent_of(input cfg_t c, input logic [PAR_W-1:0] i);
    logic [7:0] sh;
    sh = c.parent_map >> {i, 1'b0};
    if (i == '0 || int'(i) >= NUM_BUSES) begin
      return '0;
    end
    return sh[PAR_W-1:0];
  endfunction

  function automatic logic muted(input cfg_t c, input logic [PAR_W-1:0] i);
    return (i != '0) && (int'(i) < NUM_BUSES) && c.mute_mask[i];
  endfunction

  function automatic logic soloed(input cfg_t c, input logic [PAR_W-1:0] i);
    return (i != '0) && (int'(i) < NUM_BUSES) && c.solo_mask[i];
  endfunction

  function automatic logic any_solo(input cfg_t c);
    logic s;
    s = 1'b0;
    for (int i = 1; i < NUM_BUSES; i++) begin
      s = s | soloed(c, PAR_W'(i));
    end
    return s;
  endfunction

endpackage

@@ hdl/gbr_entry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_entry: input stage
// Clamps the listener volume and seeds one lane per category bus with its
// own gain, mute and solo bits and its first parent.
// ----------------------------------------------------------------------------
module gbr_entry import gbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  logic [IDX_W-1:0]  bus_index,
  input  logic [GAIN_W-1:0] listener_volume,
  input  cfg_t              cfg,
  output logic              vld_o,
  output item_t             item_o
);

  logic  vld_r;
  item_t item_r, item_nxt;

  // Build the seeded word
  always_comb begin
    logic [PAR_W-1:0] b;
    item_nxt.bus_index = bus_index;
    item_nxt.lv        = (listener_volume > UNITY) ? UNITY : listener_volume;
    for (int l = 0; l < NUM_LANES; l++) begin
      b = PAR_W'(l + 1);
      item_nxt.lanes[l].gain       = gain_of(cfg, b);
      item_nxt.lanes[l].cur        = parent_of(cfg, b);
      item_nxt.lanes[l].mute       = muted(cfg, b);
      item_nxt.lanes[l].self_solo  = soloed(cfg, b);
      item_nxt.lanes[l].chain_solo = 1'b0;
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

@@ hdl/gbr_hop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_hop: one hop of the parent walk
// Every lane still short of master folds in its current parent's gain, mute
// and solo and steps to the next parent.
// ----------------------------------------------------------------------------
module gbr_hop import gbr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  vld_i,
  input  item_t item_i,
  input  cfg_t  cfg,
  output logic  vld_o,
  output item_t item_o
);

  logic  vld_r;
  item_t item_r, item_nxt;

  // Take one step on each lane
  always_comb begin
    item_nxt = item_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (item_i.lanes[l].cur != '0) begin
        item_nxt.lanes[l].gain = qmul(item_i.lanes[l].gain,
                                      gain_of(cfg, item_i.lanes[l].cur));
        item_nxt.lanes[l].mute = item_i.lanes[l].mute |
                                 muted(cfg, item_i.lanes[l].cur);
        item_nxt.lanes[l].chain_solo = item_i.lanes[l].chain_solo |
                                       soloed(cfg, item_i.lanes[l].cur);
        item_nxt.lanes[l].cur  = parent_of(cfg, item_i.lanes[l].cur);
      end
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

@@ hdl/gbr_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_finish: master gain and result stages
// Applies the master gain to every lane, then picks the queried bus, scales
// by the listener volume and resolves mute, solo and the mixable summary.
// ----------------------------------------------------------------------------
module gbr_finish import gbr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  vld_i,
  input  item_t item_i,
  input  cfg_t  cfg,
  output logic  vld_o,
  output res_t  res_o
);

  logic vld_m_r;
  mst_t mst_r, mst_nxt;
  logic vld_o_r;
  res_t res_r, res_nxt;

  // Apply master gain per lane
  always_comb begin
    mst_nxt.bus_index = item_i.bus_index;
    mst_nxt.lv        = item_i.lv;
    for (int l = 0; l < NUM_LANES; l++) begin
      mst_nxt.lanes[l].eff     = qmul(item_i.lanes[l].gain, gain_of(cfg, '0));
      mst_nxt.lanes[l].mute    = item_i.lanes[l].mute;
      mst_nxt.lanes[l].covered = item_i.lanes[l].self_solo |
                                 item_i.lanes[l].chain_solo;
    end
  end

  // Resolve the queried bus
  always_comb begin
    logic [GAIN_W-1:0] g0;
    logic [GAIN_W-1:0] eff;
    logic              silent;
    logic              ssil;
    logic              mix;
    logic              valid;
    logic              lv_on;
    logic              solo_any;
    logic              anym;
    logic              l_sil;
    logic              l_ssil;
    g0       = gain_of(cfg, '0);
    solo_any = any_solo(cfg);
    lv_on    = (mst_r.lv != '0);
    valid    = (mst_r.bus_index < IDX_W'(NUM_BUSES));
    eff      = g0;
    silent   = (g0 == '0);
    ssil     = 1'b0;
    mix      = (g0 != '0);
    anym     = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      l_sil  = mst_r.lanes[l].mute | (mst_r.lanes[l].eff == '0);
      l_ssil = solo_any & ~mst_r.lanes[l].covered;
      anym   = anym | (~l_sil & ~l_ssil);
      if (mst_r.bus_index == IDX_W'(l + 1)) begin
        eff    = mst_r.lanes[l].eff;
        silent = l_sil;
        ssil   = l_ssil;
        mix    = ~l_sil & ~l_ssil;
      end
    end
    if (!valid) begin
      silent = 1'b0;
      ssil   = 1'b0;
    end
    res_nxt.output_gain   = valid ? qmul(mst_r.lv, eff) : mst_r.lv;
    res_nxt.mix_enable    = valid & mix & lv_on;
    res_nxt.mix_gain      = res_nxt.mix_enable ? res_nxt.output_gain : '0;
    res_nxt.bus_silent    = silent;
    res_nxt.solo_silenced = ssil;
    res_nxt.any_mixable   = anym & lv_on & (g0 != '0);
    res_nxt.bus_valid     = valid;
  end

  // Advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_o_r <= 1'b0;
    end else if (adv) begin
      vld_m_r <= vld_i;
      vld_o_r <= vld_m_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      mst_r <= mst_nxt;
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_o_r;
  assign res_o = res_r;

endmodule

@@ hdl/audio_bus_gain_resolver.sv @@
// An accepted word reaches out_valid through NUM_BUSES + 3 register stages: entry,
// one per hop, master gain, result.
// Throughput: one word per cycle while the output is not stalled; the parent walk is one register stage per hop.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
// Reset (rst_n low, synchronous) empties the pipeline, sets all gains to unity
// and clears the parent map and the mute and solo masks.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_bus_gain_resolver: per-listener mix gain of one audio bus
// Walks the bus's parent chain toward master, multiplies gains in Q1.15,
// applies master gain and listener volume, and resolves mute and solo.
// ----------------------------------------------------------------------------
module audio_bus_gain_resolver import gbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_bus_index,
  input  logic [GAIN_W-1:0] in_listener_volume,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GAIN_W-1:0] out_mix_gain,
  output logic [GAIN_W-1:0] out_output_gain,
  output logic              out_mix_enable,
  output logic              out_bus_silent,
  output logic              out_solo_silenced,
  output logic              out_any_mixable,
  output logic              out_bus_valid,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r;
  logic  adv;
  logic  vld_s  [NUM_BUSES+1];
  item_t item_s [NUM_BUSES+1];
  res_t  res;

  // Hold the pipeline while the output word waits
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain       <= {4{UNITY}};
      cfg_r.parent_map <= '0;
      cfg_r.mute_mask  <= '0;
      cfg_r.solo_mask  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MASTER_GAIN: cfg_r.gain[0]    <= cfg_wdata;
        REG_BUS1_GAIN:   cfg_r.gain[1]    <= cfg_wdata;
        REG_BUS2_GAIN:   cfg_r.gain[2]    <= cfg_wdata;
        REG_BUS3_GAIN:   cfg_r.gain[3]    <= cfg_wdata;
        REG_PARENT_MAP:  cfg_r.parent_map <= cfg_wdata[7:0];
        REG_MUTE_MASK:   cfg_r.mute_mask  <= cfg_wdata[3:0];
        REG_SOLO_MASK:   cfg_r.solo_mask  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  gbr_entry u_entry (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .vld_i           (in_valid),
    .bus_index       (in_bus_index),
    .listener_volume (in_listener_volume),
    .cfg             (cfg_r),
    .vld_o           (vld_s[0]),
    .item_o          (item_s[0])
  );

  // One stage per hop of the parent walk
  for (genvar h = 0; h < NUM_BUSES; h++) begin : g_hop
    gbr_hop u_hop (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .vld_i  (vld_s[h]),
      .item_i (item_s[h]),
      .cfg    (cfg_r),
      .vld_o  (vld_s[h+1]),
      .item_o (item_s[h+1])
    );
  end

  gbr_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (vld_s[NUM_BUSES]),
    .item_i (item_s[NUM_BUSES]),
    .cfg    (cfg_r),
    .vld_o  (out_valid),
    .res_o  (res)
  );

  assign out_mix_gain      = res.mix_gain;
  assign out_output_gain   = res.output_gain;
  assign out_mix_enable    = res.mix_enable;
  assign out_bus_silent    = res.bus_silent;
  assign out_solo_silenced = res.solo_silenced;
  assign out_any_mixable   = res.any_mixable;
  assign out_bus_valid     = res.bus_valid;

endmodule
